// ----- rtl/b64d_pkg.sv -----
package b64d_pkg;

  localparam int unsigned NumBytes = 3;

  localparam logic [6:0] PadValue = 7'd64;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LENGTH   = 2'd1,
    ST_BAD_CHAR = 2'd2
  } status_e;

  typedef struct packed {
    logic       bad;
    logic [6:0] value;
  } sextet_t;

  typedef struct packed {
    logic [1:0]             count;
    logic [NumBytes-1:0][7:0] bytes;
    status_e                status;
    logic                   eos;
  } bundle_t;

  typedef struct packed {
    logic    has_result;
    bundle_t bundle;
  } group_res_t;

  function automatic sextet_t map_char(logic [7:0] c);
    sextet_t    s;
    logic [7:0] diff;
    s    = '{bad: 1'b0, value: 7'd0};
    diff = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      diff    = c - 8'h41;
      s.value = diff[6:0];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      diff    = c - 8'h61 + 8'd26;
      s.value = diff[6:0];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      diff    = c - 8'h30 + 8'd52;
      s.value = diff[6:0];
    end else if (c == 8'h2D) begin
      s.value = 7'd62;
    end else if (c == 8'h5F) begin
      s.value = 7'd63;
    end else if (c == 8'h2E) begin
      s.value = PadValue;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

// ----- rtl/b64d_group.sv -----
module b64d_group
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [7:0] code_char_i,
  input  logic       eot_i,
  output group_res_t res_o
);

  logic [6:0] sext_q [3];
  logic [6:0] sext_d [3];
  logic [1:0] pos_q, pos_d;
  logic       bad_q, bad_d;

  sextet_t    cur;
  logic [6:0] v;
  logic       bad_n;
  logic [5:0] s0, s1, s2, s3;

  always_comb begin
    cur   = map_char(code_char_i);
    v     = cur.bad ? 7'd0 : cur.value;
    bad_n = bad_q | cur.bad;
    s0    = sext_q[0][5:0];
    s1    = sext_q[1][5:0];
    s2    = sext_q[2][5:0];
    s3    = v[5:0];

    sext_d = sext_q;
    pos_d  = pos_q;
    bad_d  = bad_n;

    res_o                   = '0;
    res_o.bundle.count      = 2'd1;
    res_o.bundle.status     = ST_OK;
    res_o.bundle.eos        = eot_i;

    if (pos_q != 2'd3) begin
      sext_d[pos_q] = v;
      pos_d         = pos_q + 2'd1;
      if (eot_i) begin
        res_o.has_result    = 1'b1;
        res_o.bundle.status = bad_n ? ST_BAD_CHAR : ST_LENGTH;
      end
    end else begin
      res_o.has_result = 1'b1;
      if (bad_n || sext_q[0][6] || sext_q[1][6]) begin
        res_o.bundle.status = ST_BAD_CHAR;
      end else begin
        res_o.bundle.bytes[0] = {s0, s1[5:4]};
        res_o.bundle.bytes[1] = {s1[3:0], s2[5:2]};
        res_o.bundle.bytes[2] = {s2[1:0], s3};
        if (!sext_q[2][6]) begin
          res_o.bundle.count = v[6] ? 2'd2 : 2'd3;
        end
      end
    end

    if (res_o.has_result) begin
      sext_d = '{default: 7'd0};
      pos_d  = 2'd0;
      bad_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sext_q <= '{default: 7'd0};
      pos_q  <= 2'd0;
      bad_q  <= 1'b0;
    end else if (adv_i) begin
      sext_q <= sext_d;
      pos_q  <= pos_d;
      bad_q  <= bad_d;
    end
  end

endmodule

// ----- rtl/b64d_out_buf.sv -----
module b64d_out_buf
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  bundle_t    bundle_i,
  output logic       free_o,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       last_of_group_o,
  output logic       end_of_stream_o,
  output logic [1:0] status_o
);

  logic       valid_q, valid_d;
  bundle_t    bundle_q;
  logic [1:0] idx_q, idx_d;
  logic       xfer, last;

  always_comb begin
    last    = (idx_q == bundle_q.count - 2'd1);
    xfer    = valid_q && !stall_i;
    free_o  = !valid_q || (xfer && last);
    valid_d = valid_q;
    idx_d   = idx_q;
    if (xfer) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

  assign valid_o         = valid_q;
  assign data_byte_o     = bundle_q.bytes[idx_q];
  assign byte_valid_o    = (bundle_q.status == ST_OK);
  assign last_of_group_o = last;
  assign end_of_stream_o = bundle_q.eos && last;
  assign status_o        = bundle_q.status;

endmodule

// ----- rtl/base64_url_dot_pad_decoder_core.sv -----
// Characters go through the input register; a result loads the output bundle register.
// Throughput: one character per cycle while stall_o is low; a group that completes
// drains up to three bytes, one per cycle while stall_i is low, as input goes on.
// Input backs up only when a result-producing character meets a bundle still draining.
// Reset: rst_ni asynchronous, active low; clears valids and the group state.
module base64_url_dot_pad_decoder_core
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] code_char_i,
  input  logic       end_of_text_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       last_of_group_o,
  output logic       end_of_stream_o,
  output logic [1:0] status_o
);

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_eot_q;
  logic       adv;
  logic       buf_free;
  group_res_t res;

  assign adv     = in_valid_q && (!res.has_result || buf_free);
  assign stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!stall_o) begin
      in_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      in_char_q <= code_char_i;
      in_eot_q  <= end_of_text_i;
    end
  end

  b64d_group u_group (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .code_char_i (in_char_q),
    .eot_i       (in_eot_q),
    .res_o       (res)
  );

  b64d_out_buf u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (adv && res.has_result),
    .bundle_i        (res.bundle),
    .free_o          (buf_free),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .data_byte_o     (data_byte_o),
    .byte_valid_o    (byte_valid_o),
    .last_of_group_o (last_of_group_o),
    .end_of_stream_o (end_of_stream_o),
    .status_o        (status_o)
  );

endmodule

// ----- rtl/b64d_checker.sv -----
module b64d_checker
  import b64d_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_o,
  input logic       stall_i,
  input logic [7:0] data_byte_o,
  input logic       byte_valid_o,
  input logic       last_of_group_o,
  input logic       end_of_stream_o,
  input logic [1:0] status_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(data_byte_o) && $stable(status_o))
    else $error("stalled output changed");

  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && byte_valid_o |-> status_o == ST_OK)
    else $error("byte with error status");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !byte_valid_o |-> data_byte_o == 8'd0 && last_of_group_o)
    else $error("error result not a single zero result");

  a_eos_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && end_of_stream_o |-> last_of_group_o)
    else $error("end of stream before last of group");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> status_o == ST_OK || status_o == ST_LENGTH || status_o == ST_BAD_CHAR)
    else $error("status code out of range");

endmodule

bind base64_url_dot_pad_decoder_core b64d_checker u_chk (.*);

// ----- tb/tb_base64_url_dot_pad_decoder_core.sv -----
`timescale 1ns / 100ps

import b64d_pkg::*;

typedef struct {
  logic [7:0] data;
  logic       valid;
  logic       last;
  logic       eos;
  status_e    status;
} decoded_t;

class b64_byte_scoreboard;
  localparam logic [7:0] InvalidCode = 8'hFF;

  logic [6:0] held_sextet[3];
  logic [1:0] held_count;
  bit         saw_bad;
  decoded_t   expected_bytes[$];
  int         fail_count;
  int         result_count;
  int         error_results;

  function new();
    fail_count    = 0;
    result_count  = 0;
    error_results = 0;
    clear_group();
  endfunction

  function void clear_group();
    held_sextet[0] = '0;
    held_sextet[1] = '0;
    held_sextet[2] = '0;
    held_count     = '0;
    saw_bad        = 1'b0;
  endfunction

  function logic [7:0] sextet_of(logic [7:0] c);
    if (c >= "A" && c <= "Z") return c - 8'd65;
    if (c >= "a" && c <= "z") return c - 8'd97 + 8'd26;
    if (c >= "0" && c <= "9") return c - 8'd48 + 8'd52;
    if (c == "-") return 8'd62;
    if (c == "_") return 8'd63;
    if (c == ".") return {1'b0, PadValue};
    return InvalidCode;
  endfunction

  function void push(logic [7:0] data, logic valid, logic last, logic eos, status_e st);
    decoded_t e;
    e.data   = data;
    e.valid  = valid;
    e.last   = last;
    e.eos    = eos;
    e.status = st;
    expected_bytes.push_back(e);
  endfunction

  function void note_char(logic [7:0] c, logic eot);
    logic [7:0] code;
    logic [6:0] s0, s1, s2, s3;
    int         n;
    code = sextet_of(c);
    if (code == InvalidCode) begin
      saw_bad = 1'b1;
      code    = 8'd0;
    end
    if (held_count < 2'd3) begin
      held_sextet[held_count] = code[6:0];
      held_count = held_count + 2'd1;
      if (eot) begin
        push(8'd0, 1'b0, 1'b1, 1'b1, saw_bad ? ST_BAD_CHAR : ST_LENGTH);
        clear_group();
      end
      return;
    end
    s0 = held_sextet[0];
    s1 = held_sextet[1];
    s2 = held_sextet[2];
    s3 = code[6:0];
    if (saw_bad || s0 >= PadValue || s1 >= PadValue) begin
      push(8'd0, 1'b0, 1'b1, eot, ST_BAD_CHAR);
      clear_group();
      return;
    end
    n = 1;
    if (s2 < PadValue) begin
      n = 2;
      if (s3 < PadValue) n = 3;
    end
    push({s0[5:0], s1[5:4]}, 1'b1, n == 1, eot && n == 1, ST_OK);
    if (n >= 2) push({s1[3:0], s2[5:2]}, 1'b1, n == 2, eot && n == 2, ST_OK);
    if (n == 3) push({s2[1:0], s3[5:0]}, 1'b1, 1'b1, eot, ST_OK);
    clear_group();
  endfunction

  function void check_byte(logic [7:0] data, logic valid, logic last, logic eos,
                           logic [1:0] status);
    decoded_t e;
    if (expected_bytes.size() == 0) begin
      $error("unexpected result: data_byte %h status %0d", data, status);
      fail_count++;
      return;
    end
    e = expected_bytes.pop_front();
    result_count++;
    if (e.status != ST_OK) error_results++;
    if (data !== e.data) begin
      $error("data_byte: expected %h, actual %h", e.data, data);
      fail_count++;
    end
    if (valid !== e.valid) begin
      $error("byte_valid: expected %b, actual %b", e.valid, valid);
      fail_count++;
    end
    if (last !== e.last) begin
      $error("last_of_group: expected %b, actual %b", e.last, last);
      fail_count++;
    end
    if (eos !== e.eos) begin
      $error("end_of_stream: expected %b, actual %b", e.eos, eos);
      fail_count++;
    end
    if (status !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, status);
      fail_count++;
    end
  endfunction

  function int pending();
    return expected_bytes.size();
  endfunction
endclass

module tb_base64_url_dot_pad_decoder_core;
  localparam int    HoldCycles  = 300;
  localparam int    DrainCycles = 8;
  localparam string Alphabet    =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
  localparam logic [7:0] PadChar = 8'h2E;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       valid_i       = 1'b0;
  logic       stall_o;
  logic [7:0] code_char_i   = 8'd0;
  logic       end_of_text_i = 1'b0;
  logic       valid_o;
  logic       stall_i       = 1'b0;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic       last_of_group_o;
  logic       end_of_stream_o;
  logic [1:0] status_o;

  b64_byte_scoreboard sb = new();

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_req    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int char_count  = 0;
  int string_count = 0;

  base64_url_dot_pad_decoder_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .code_char_i    (code_char_i),
    .end_of_text_i  (end_of_text_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .data_byte_o    (data_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_of_group_o(last_of_group_o),
    .end_of_stream_o(end_of_stream_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        sb.check_byte(data_byte_o, byte_valid_o, last_of_group_o, end_of_stream_o, status_o);
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_i <= 1'b1;
      end else begin
        stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_char(logic [7:0] c, logic eot);
    while ($urandom_range(0, 99) < idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i       <= 1'b1;
    code_char_i   <= c;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (stall_o);
    sb.note_char(c, eot);
    char_count++;
    if (eot) string_count++;
  endtask

  task automatic send_word(string s, logic eot_last);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], eot_last && (i == s.len() - 1));
    end
  endtask

  task automatic send_good_stream();
    int         groups;
    int         pads;
    logic [7:0] c;
    groups = $urandom_range(1, 4);
    pads   = $urandom_range(0, 2);
    for (int i = 0; i < groups * 4; i++) begin
      if (i >= groups * 4 - pads) c = PadChar;
      else c = Alphabet[$urandom_range(0, 63)];
      send_char(c, i == groups * 4 - 1);
    end
  endtask

  task automatic send_broken_stream();
    int         len;
    logic [7:0] c;
    len = $urandom_range(1, 9);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 2))
        0: c = 8'($urandom_range(0, 255));
        1: c = PadChar;
        default: c = Alphabet[$urandom_range(0, 63)];
      endcase
      send_char(c, (i == len - 1) && ($urandom_range(0, 3) != 0));
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(int send_idle, int recv_stall, int min_chars);
    int start;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    start     = char_count;
    while (char_count - start < min_chars) begin
      if ($urandom_range(0, 9) < 7) send_good_stream();
      else send_broken_stream();
    end
    valid_i <= 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word("TWFu", 1'b0);
    send_word("TQ.A", 1'b0);
    send_word(".AAA", 1'b0);
    send_word("A.AA", 1'b0);
    send_char(8'h00, 1'b0);
    send_word("Zaz", 1'b0);
    send_word("_-09", 1'b1);
    send_char(8'hFF, 1'b0);
    send_word("x", 1'b1);
    send_word("A", 1'b1);
    valid_i <= 1'b0;
    wait_drained();

    // long receiver hold-off while the sender keeps pushing
    hold_req++;
    run_phase(0, 0, 72);
    run_phase(85, 0, 72);
    run_phase(0, 85, 72);
    run_phase(28, 28, 72);

    wait_drained();
    $display("Checked %0d results (%0d error results) from %0d characters, %0d strings.",
             sb.result_count, sb.error_results, char_count, string_count);
    $display("Ran free-flowing, sender-idle, receiver-stall and mixed traffic plus one hold-off.");
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/b64d_pkg.sv
rtl/b64d_group.sv
rtl/b64d_out_buf.sv
rtl/base64_url_dot_pad_decoder_core.sv
rtl/b64d_checker.sv
tb/tb_base64_url_dot_pad_decoder_core.sv
